/* src/cfd_pkg.sv */
// Shared types, widths and codes of the constant-fraction discriminator.
`default_nettype none
package cfd_pkg;

  typedef struct packed {
    logic signed [15:0] sample;
    logic               last;
  } cfd_in_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] position;
  } cfd_out_t;

  typedef struct packed {
    logic busy;
    logic done;
  } cfd_div_stat_t;

  localparam logic [1:0] ST_FOUND  = 2'd0;
  localparam logic [1:0] ST_NONE   = 2'd1;
  localparam logic [1:0] ST_NOCONV = 2'd2;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 18;

  localparam logic [CFG_IDX_W-1:0] REG_DELAY  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAC   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_WALK   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_THRESH = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_MAXIT  = 3'd5;

  localparam int QB     = 20;
  localparam int A_W    = 36;
  localparam int C_W    = 42;
  localparam int U_W    = 24;
  localparam int NU_W   = 26;
  localparam int G1_W   = 35;
  localparam int DG1_W  = 37;
  localparam int G2_W   = 39;
  localparam int DG2_W  = 40;
  localparam int G3_W   = 42;
  localparam int MA_W   = 40;
  localparam int MB_W   = 24;
  localparam int P_W    = 64;
  localparam int NUM_W  = 62;
  localparam int DEN_W  = 40;
  localparam int STEP_W = 7;

  typedef enum logic [4:0] {
    S_IDLE,
    S_ARD,
    S_ACALC,
    S_TEST,
    S_COEF,
    S_MAX,
    S_SHC,
    S_RND,
    S_SHL,
    S_N0,
    S_N1,
    S_N2,
    S_N3,
    S_N4,
    S_N5,
    S_N6,
    S_N7,
    S_FIN
  } cfd_state_e;

endpackage
`default_nettype wire

/* src/cfd_hist.sv */
// Sample history ring buffer with the four most recent samples held in taps.
`default_nettype none
module cfd_hist #(
  parameter int unsigned ADDR_W = 7
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  logic signed [15:0]  sample_i,
  input  logic [ADDR_W-1:0]   back_i,
  output logic [15:0]         rdata_o,
  output logic [3:0][15:0]    tap_o
);
  import cfd_pkg::*;

  logic [15:0]       mem_q [2**ADDR_W];
  logic [ADDR_W-1:0] wptr_q, wptr_d;
  logic [ADDR_W-1:0] wr_addr, rd_addr;
  logic [15:0]       rdata_q;
  logic [3:0][15:0]  tap_q;

  assign wr_addr = wptr_q + ADDR_W'(1);
  assign rd_addr = wptr_q - back_i;
  assign wptr_d  = push_i ? wr_addr : wptr_q;

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_addr] <= sample_i;
    end
    rdata_q <= mem_q[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      tap_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      if (push_i) begin
        tap_q <= {tap_q[2:0], sample_i};
      end
    end
  end

  assign rdata_o = rdata_q;
  assign tap_o   = tap_q;

endmodule
`default_nettype wire

/* src/cfd_mul.sv */
// Shared signed multiplier with a registered product.
`default_nettype none
module cfd_mul (
  input  logic                          clk_i,
  input  logic signed [cfd_pkg::MA_W-1:0] a_i,
  input  logic signed [cfd_pkg::MB_W-1:0] b_i,
  output logic signed [cfd_pkg::P_W-1:0]  p_o
);
  import cfd_pkg::*;

  logic signed [P_W-1:0] p_q;

  always_ff @(posedge clk_i) begin
    p_q <= P_W'(a_i) * P_W'(b_i);
  end

  assign p_o = p_q;

endmodule
`default_nettype wire

/* src/cfd_div.sv */
// Restoring divider for unsigned magnitudes, one quotient bit per cycle.
`default_nettype none
module cfd_div (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [cfd_pkg::NUM_W-1:0]     num_i,
  input  logic [cfd_pkg::DEN_W-1:0]     den_i,
  output cfd_pkg::cfd_div_stat_t        stat_o,
  output logic [cfd_pkg::NUM_W-1:0]     quo_o
);
  import cfd_pkg::*;

  localparam int CNT_W = $clog2(NUM_W);

  logic             busy_q, done_q;
  logic [CNT_W-1:0] cnt_q;
  logic [NUM_W-1:0] num_q, quo_q;
  logic [DEN_W-1:0] rem_q, den_q;
  logic [DEN_W:0]   rem_s, rem_n;
  logic             ge;

  assign rem_s = {rem_q, num_q[NUM_W-1]};
  assign ge    = rem_s >= {1'b0, den_q};
  assign rem_n = ge ? rem_s - {1'b0, den_q} : rem_s;

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= num_i;
      den_q <= den_i;
      rem_q <= '0;
      quo_q <= '0;
    end else if (busy_q) begin
      num_q <= {num_q[NUM_W-2:0], 1'b0};
      rem_q <= rem_n[DEN_W-1:0];
      quo_q <= {quo_q[NUM_W-2:0], ge};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + CNT_W'(1);
        if (cnt_q == CNT_W'(NUM_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign quo_o       = quo_q;

endmodule
`default_nettype wire

/* src/constant_fraction_discriminator.sv */
// Top level of the constant-fraction discriminator with cubic Newton refinement.
//
//   Channel   Direction  Handshake                  Payload
//   in        input      in_valid_i / in_ready_o    in_data_i  (sample, last)
//   out       output     out_valid_o / out_ready_i  out_data_o (status, position)
//   cfg       input      cfg_we_i                   cfg_idx_i, cfg_data_i
//
// A sample that starts no search is taken in S_IDLE, and a last sample passes through S_FIN for its result.
// A search candidate computes the constant-fraction values and the test, then the coefficients
// and their scaling, then Newton steps (max_iterations+2 steps at most), each one waiting
// on the serial divider.
// Reset clears the control state; the history memory needs no clearing pass.
// A result waits in the output register; a further result stalls the input until it leaves.
`default_nettype none
module constant_fraction_discriminator #(
  parameter int unsigned MAX_DELAY  = 64,
  parameter int unsigned INDEX_BITS = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  cfd_pkg::cfd_in_t                    in_data_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output cfd_pkg::cfd_out_t                   out_data_o,
  input  logic                                cfg_we_i,
  input  logic [cfd_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [cfd_pkg::CFG_DATA_W-1:0]      cfg_data_i
);
  import cfd_pkg::*;

  localparam int HA_W = $clog2(MAX_DELAY + 4);
  localparam int NW   = ((INDEX_BITS > HA_W) ? INDEX_BITS : HA_W) + 1;
  localparam int PS_W = (INDEX_BITS + 18 > 34) ? INDEX_BITS + 18 : 34;

  logic [6:0]         delay_q;
  logic [15:0]        frac_q;
  logic signed [15:0] offset_q;
  logic signed [17:0] walk_q;
  logic [16:0]        thr_q;
  logic [5:0]         maxit_q;

  cfd_state_e state_q, state_d;

  logic [INDEX_BITS-1:0] n_q, cand_q;
  logic                  last_q, found_q;
  logic [1:0]            status_q;
  logic [31:0]           pos_q;
  logic                  out_valid_q;
  cfd_out_t              out_q;
  logic [1:0]            kq_q, jq_q;
  logic [3:0]            sh_q;
  logic [STEP_W-1:0]     step_q;

  logic signed [A_W-1:0]   av_q [4];
  logic signed [C_W-1:0]   d1_q, d2_q, d3_q;
  logic signed [C_W-1:0]   c_q [4];
  logic [C_W-1:0]          m_q;
  logic signed [U_W-1:0]   u_q;
  logic signed [G1_W-1:0]  g1_q;
  logic signed [DG1_W-1:0] dg1_q;
  logic signed [G2_W-1:0]  g2_q;
  logic signed [DG2_W-1:0] dg2_q;
  logic signed [G3_W-1:0]  g3_q;
  logic                    neg_q;

  logic                     accept, examine, fin_sel, load_out;
  logic [HA_W-1:0]          d_eff, back;
  logic [15:0]              rdata;
  logic [3:0][15:0]         taps;
  logic signed [MA_W-1:0]   mul_a;
  logic signed [MB_W-1:0]   mul_b;
  logic signed [P_W-1:0]    p_q, p3;
  logic                     div_start;
  cfd_div_stat_t            div_stat;
  logic [NUM_W-1:0]         quo;
  logic signed [16:0]       off_x, fx_k, fx2, fd;
  logic [16:0]              fx2_mag;
  logic signed [A_W-1:0]    a_new, a0, a1, a2, a3;
  logic                     test_ok;
  logic [C_W-1:0]           cm [4];
  logic [C_W-1:0]           m01, m23, m_all;
  logic signed [C_W:0]      rnd_sum, half;
  logic signed [G3_W-1:0]   g3_abs;
  logic signed [DG2_W-1:0]  dg2_abs;
  logic signed [NU_W-1:0]   qs, nu;
  logic                     q_big, nu_out, q_conv, step_last;
  logic signed [PS_W-1:0]   pos_s;
  logic [31:0]              pos_sat;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      delay_q  <= 7'd1;
      frac_q   <= 16'd32768;
      offset_q <= '0;
      walk_q   <= '0;
      thr_q    <= '0;
      maxit_q  <= 6'd20;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_DELAY:  delay_q  <= cfg_data_i[6:0];
        REG_FRAC:   frac_q   <= cfg_data_i[15:0];
        REG_OFFSET: offset_q <= cfg_data_i[15:0];
        REG_WALK:   walk_q   <= cfg_data_i[17:0];
        REG_THRESH: thr_q    <= cfg_data_i[16:0];
        REG_MAXIT:  maxit_q  <= cfg_data_i[5:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (delay_q == 7'd0) begin
      d_eff = HA_W'(1);
    end else if (int'(delay_q) > int'(MAX_DELAY)) begin
      d_eff = HA_W'(MAX_DELAY);
    end else begin
      d_eff = HA_W'(delay_q);
    end
  end

  assign accept  = in_valid_i && (state_q == S_IDLE);
  assign examine = (n_q != '1) && !found_q &&
                   (NW'(n_q) >= NW'(d_eff) + NW'(3));
  assign back    = HA_W'(kq_q) + d_eff;

  cfd_hist #(.ADDR_W(HA_W)) u_hist (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (accept),
    .sample_i (in_data_i.sample),
    .back_i   (back),
    .rdata_o  (rdata),
    .tap_o    (taps)
  );

  cfd_mul u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (p_q)
  );

  cfd_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (NUM_W'(g3_abs) << QB),
    .den_i   (DEN_W'(dg2_abs)),
    .stat_o  (div_stat),
    .quo_o   (quo)
  );

  // Datapath arithmetic.
  always_comb begin
    off_x   = {offset_q[15], offset_q};
    fx_k    = $signed({taps[kq_q][15], taps[kq_q]}) - off_x;
    fx2     = $signed({taps[2][15], taps[2]}) - off_x;
    fx2_mag = fx2[16] ? 17'(-fx2) : 17'(fx2);
    fd      = $signed({rdata[15], rdata}) - off_x;
    a_new   = (A_W'(fd) <<< 16) - A_W'(p_q) - (A_W'(walk_q) <<< 16);
    a0      = av_q[3];
    a1      = av_q[2];
    a2      = av_q[1];
    a3      = av_q[0];
    test_ok = (((a1 <= 0) && (a2 >= 0)) || ((a1 >= 0) && (a2 <= 0))) &&
              (fx2_mag > thr_q) && (a1 != a2) && !((a1 != 0) && (a2 == 0)) &&
              !((a1 > a2) && (fx2 > 0)) && !((a1 < a2) && (fx2 < 0));
    for (int j = 0; j < 4; j++) begin
      cm[j] = c_q[j][C_W-1] ? C_W'(-c_q[j]) : C_W'(c_q[j]);
    end
    m01     = (cm[0] > cm[1]) ? cm[0] : cm[1];
    m23     = (cm[2] > cm[3]) ? cm[2] : cm[3];
    m_all   = (m01 > m23) ? m01 : m23;
    half    = $signed((C_W+1)'(1) << (sh_q - 4'd1));
    rnd_sum = (C_W+1)'(c_q[jq_q]) + half;
    p3      = p_q + (p_q <<< 1);
    g3_abs  = g3_q[G3_W-1] ? -g3_q : g3_q;
    dg2_abs = dg2_q[DG2_W-1] ? -dg2_q : dg2_q;
    q_big   = quo > (NUM_W'(1) << 24);
    qs      = $signed({1'b0, quo[NU_W-2:0]});
    nu      = NU_W'(u_q) - (neg_q ? -qs : qs);
    nu_out  = (nu >= (NU_W'(1) <<< 23)) || (nu <= -(NU_W'(1) <<< 23));
    q_conv  = quo <= NUM_W'(1);
    step_last = (step_q + STEP_W'(1)) == (STEP_W'(maxit_q) + STEP_W'(2));
    pos_s   = $signed(PS_W'({cand_q, 16'b0})) + PS_W'((nu + NU_W'(8)) >>> 4);
    if (pos_s < 0) begin
      pos_sat = '0;
    end else if (pos_s[PS_W-1:32] != '0) begin
      pos_sat = '1;
    end else begin
      pos_sat = pos_s[31:0];
    end
  end

  // Sequencer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d   = state_q;
    mul_a     = '0;
    mul_b     = '0;
    div_start = 1'b0;
    load_out  = 1'b0;
    fin_sel   = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (examine && (n_q != '1)) begin
            state_d = S_ARD;
          end else if (in_data_i.last) begin
            state_d = S_FIN;
          end
        end
      end
      S_ARD: begin
        mul_a   = MA_W'(fx_k);
        mul_b   = MB_W'($signed({1'b0, frac_q}));
        state_d = S_ACALC;
      end
      S_ACALC: state_d = (kq_q == 2'd3) ? S_TEST : S_ARD;
      S_TEST: begin
        if (test_ok) begin
          state_d = S_COEF;
        end else begin
          fin_sel = 1'b1;
        end
      end
      S_COEF: state_d = S_MAX;
      S_MAX: begin
        if (m_all == '0) begin
          fin_sel = 1'b1;
        end else if (m_all >= (C_W'(1) << 30)) begin
          state_d = S_SHC;
        end else begin
          state_d = S_SHL;
        end
      end
      S_SHC: if (m_q < (C_W'(1) << 30)) state_d = S_RND;
      S_RND: if (jq_q == 2'd3) state_d = S_N0;
      S_SHL: if (m_q >= (C_W'(1) << 29)) state_d = S_N0;
      S_N0: begin
        mul_a   = MA_W'(c_q[3]);
        mul_b   = u_q;
        state_d = S_N1;
      end
      S_N1: state_d = S_N2;
      S_N2: begin
        mul_a   = MA_W'(g1_q);
        mul_b   = u_q;
        state_d = S_N3;
      end
      S_N3: begin
        mul_a   = MA_W'(dg1_q);
        mul_b   = u_q;
        state_d = S_N4;
      end
      S_N4: begin
        mul_a   = MA_W'(g2_q);
        mul_b   = u_q;
        state_d = S_N5;
      end
      S_N5: begin
        if (dg2_q == '0) begin
          fin_sel = 1'b1;
        end else begin
          state_d = S_N6;
        end
      end
      S_N6: begin
        div_start = 1'b1;
        state_d   = S_N7;
      end
      S_N7: begin
        if (div_stat.done) begin
          if (q_big || nu_out || q_conv || step_last) begin
            fin_sel = 1'b1;
          end else begin
            state_d = S_N0;
          end
        end
      end
      S_FIN: begin
        if (!out_valid_q || out_ready_i) begin
          load_out = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
    if (fin_sel) begin
      state_d = last_q ? S_FIN : S_IDLE;
    end
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      n_q         <= '0;
      last_q      <= 1'b0;
      found_q     <= 1'b0;
      status_q    <= ST_NONE;
      pos_q       <= '0;
      out_valid_q <= 1'b0;
      kq_q        <= '0;
      jq_q        <= '0;
      sh_q        <= '0;
      step_q      <= '0;
    end else begin
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (accept) begin
        last_q <= in_data_i.last;
        kq_q   <= '0;
        if (in_data_i.last) begin
          n_q <= '0;
        end else if (n_q != '1) begin
          n_q <= n_q + INDEX_BITS'(1);
        end
      end
      if (load_out) begin
        found_q  <= 1'b0;
        status_q <= ST_NONE;
        pos_q    <= '0;
      end
      unique case (state_q)
        S_ACALC: kq_q <= kq_q + 2'd1;
        S_TEST: begin
          if (test_ok) begin
            found_q  <= 1'b1;
            status_q <= ST_NOCONV;
            pos_q    <= '0;
          end
        end
        S_MAX: begin
          sh_q   <= '0;
          jq_q   <= '0;
          step_q <= '0;
        end
        S_SHC: if (m_q >= (C_W'(1) << 30)) sh_q <= sh_q + 4'd1;
        S_RND: jq_q <= jq_q + 2'd1;
        S_N7: begin
          if (div_stat.done && !q_big && !nu_out) begin
            if (q_conv) begin
              status_q <= ST_FOUND;
              pos_q    <= pos_sat;
            end else begin
              step_q <= step_q + STEP_W'(1);
            end
          end
        end
        default: ;
      endcase
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_q.status   <= status_q;
      out_q.position <= pos_q;
    end
    if (accept) begin
      cand_q <= n_q - INDEX_BITS'(3);
    end
    unique case (state_q)
      S_ACALC: av_q[kq_q] <= a_new;
      S_TEST: begin
        d1_q <= C_W'(a1) - C_W'(a0);
        d2_q <= C_W'(a2) - (C_W'(a1) <<< 1) + C_W'(a0);
        d3_q <= C_W'(a3) - (C_W'(a2) <<< 1) - C_W'(a2) + (C_W'(a1) <<< 1) + C_W'(a1)
                - C_W'(a0);
      end
      S_COEF: begin
        c_q[0] <= (C_W'(a0) <<< 2) + (C_W'(a0) <<< 1);
        c_q[1] <= (d1_q <<< 2) + (d1_q <<< 1) - (d2_q <<< 1) - d2_q + (d3_q <<< 1);
        c_q[2] <= (d2_q <<< 1) + d2_q - (d3_q <<< 1) - d3_q;
        c_q[3] <= d3_q;
      end
      S_MAX: begin
        m_q <= m_all;
        u_q <= '0;
      end
      S_SHC: if (m_q >= (C_W'(1) << 30)) m_q <= m_q >> 1;
      S_RND: c_q[jq_q] <= C_W'(rnd_sum >>> sh_q);
      S_SHL: begin
        if (m_q < (C_W'(1) << 29)) begin
          m_q <= m_q << 1;
          for (int j = 0; j < 4; j++) begin
            c_q[j] <= c_q[j] <<< 1;
          end
        end
      end
      S_N1: begin
        g1_q  <= G1_W'((p_q >>> QB) + P_W'(c_q[2]));
        dg1_q <= DG1_W'((p3 >>> QB) + (P_W'(c_q[2]) <<< 1));
      end
      S_N3: g2_q  <= G2_W'((p_q >>> QB) + P_W'(c_q[1]));
      S_N4: dg2_q <= DG2_W'((p_q >>> QB) + P_W'(c_q[1]));
      S_N5: g3_q  <= G3_W'((p_q >>> QB) + P_W'(c_q[0]));
      S_N6: neg_q <= g3_q[G3_W-1] ^ dg2_q[DG2_W-1];
      S_N7: if (div_stat.done && !q_big && !nu_out) u_q <= U_W'(nu);
      default: ;
    endcase
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_pos_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.status != ST_FOUND) |-> (out_data_o.position == '0))
    else $error("Position is not zero on a result without a crossing.");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.status == ST_FOUND) || (out_data_o.status == ST_NONE) ||
                    (out_data_o.status == ST_NOCONV))
    else $error("Result carries an unknown status code.");

  a_found_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !found_q |-> (status_q == ST_NONE) && (pos_q == '0))
    else $error("Search state is inconsistent before a decision.");

endmodule
`default_nettype wire

/* sim/testbench.sv */
// Self-checking testbench of the constant-fraction discriminator with its own predictor.
`timescale 1ns / 100ps
module testbench;
  import cfd_pkg::*;

  class cfd_scoreboard;
    int unsigned dly, frac, thr, maxit;
    int          offs, walk;
    int          hist[68];
    int unsigned idx;
    bit          found;
    bit [31:0]   fpos;
    bit [1:0]    fst;
    cfd_out_t    pending_q[$];
    int          errors, results, crossings, samples;

    function new();
      dly = 1; frac = 32768; offs = 0; walk = 0; thr = 0; maxit = 20;
      foreach (hist[k]) hist[k] = 0;
      idx = 0; found = 0; fpos = 0; fst = ST_NONE;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] a, logic [CFG_DATA_W-1:0] v);
      case (a)
        REG_DELAY:  dly = v[6:0];
        REG_FRAC:   frac = v[15:0];
        REG_OFFSET: offs = $signed(v[15:0]);
        REG_WALK:   walk = $signed(v[17:0]);
        REG_THRESH: thr = v[16:0];
        REG_MAXIT:  maxit = v[5:0];
        default: ;
      endcase
    endfunction

    function longint cf_value(int unsigned back, int unsigned d);
      longint fx, fd;
      fx = longint'(hist[back]) - offs;
      fd = longint'(hist[back+d]) - offs;
      return fd * 65536 - fx * longint'(frac);
    endfunction

    function longint absv(longint v);
      return v < 0 ? -v : v;
    endfunction

    function bit newton(input longint c[4], output longint root);
      longint u, g, dg, delta, nu;
      u = 0;
      root = 0;
      for (int unsigned k = 0; k < maxit + 2; k++) begin
        g = ((c[3] * u) >>> QB) + c[2];
        dg = ((3 * c[3] * u) >>> QB) + 2 * c[2];
        g = ((g * u) >>> QB) + c[1];
        g = ((g * u) >>> QB) + c[0];
        dg = ((dg * u) >>> QB) + c[1];
        if (dg == 0) return 0;
        delta = (g * (longint'(1) << QB)) / dg;
        if (absv(delta) > (longint'(16) << QB)) return 0;
        nu = u - delta;
        if (absv(nu) >= (longint'(8) << QB)) return 0;
        u = nu;
        if (absv(delta) <= 1) begin
          root = u;
          return 1;
        end
      end
      return 0;
    endfunction

    function void try_candidate(int unsigned i, int unsigned d);
      longint w, a0, a1, a2, a3, d1, d2, d3, m, u, pos, fx;
      longint c[4];
      int unsigned sh;
      w = longint'(walk) * 65536;
      fx = longint'(hist[2]) - offs;
      a1 = cf_value(2, d) - w;
      a2 = cf_value(1, d) - w;
      if (!((a1 <= 0 && a2 >= 0) || (a1 >= 0 && a2 <= 0))) return;
      if (absv(fx) <= longint'(thr)) return;
      if (a1 == a2) return;
      if (a1 != 0 && a2 == 0) return;
      if (a1 > a2 && fx > 0) return;
      if (a1 < a2 && fx < 0) return;
      a0 = cf_value(3, d) - w;
      a3 = cf_value(0, d) - w;
      d1 = a1 - a0;
      d2 = a2 - 2 * a1 + a0;
      d3 = a3 - 3 * a2 + 3 * a1 - a0;
      c[0] = 6 * a0;
      c[1] = 6 * d1 - 3 * d2 + 2 * d3;
      c[2] = 3 * d2 - 3 * d3;
      c[3] = d3;
      found = 1;
      fpos = 0;
      fst = ST_NOCONV;
      m = 0;
      for (int j = 0; j < 4; j++) if (absv(c[j]) > m) m = absv(c[j]);
      if (m == 0) return;
      if (m >= (longint'(1) << 30)) begin
        sh = 0;
        while ((m >> sh) >= (longint'(1) << 30)) sh++;
        for (int j = 0; j < 4; j++) c[j] = (c[j] + (longint'(1) << (sh - 1))) >>> sh;
      end else begin
        while (m < (longint'(1) << 29)) begin
          m = m * 2;
          for (int j = 0; j < 4; j++) c[j] = c[j] * 2;
        end
      end
      if (!newton(c, u)) return;
      pos = (longint'(i) - 1) * 65536 + ((u + 8) >>> 4);
      if (pos < 0) pos = 0;
      if (pos > 64'hFFFF_FFFF) pos = 64'hFFFF_FFFF;
      fpos = pos[31:0];
      fst = ST_FOUND;
    endfunction

    function void note_sample(cfd_in_t it);
      int unsigned d;
      cfd_out_t r;
      samples++;
      d = dly;
      if (d < 1) d = 1;
      if (d > 64) d = 64;
      for (int k = 67; k > 0; k--) hist[k] = hist[k-1];
      hist[0] = it.sample;
      if (idx < 65535) begin
        if (!found && idx >= d + 3) try_candidate(idx - 2, d);
        idx++;
      end
      if (it.last) begin
        r.status = fst;
        r.position = (found && fst == ST_FOUND) ? fpos : 32'd0;
        if (r.status == ST_FOUND) crossings++;
        pending_q = {pending_q, r};
        idx = 0; found = 0; fpos = 0; fst = ST_NONE;
      end
    endfunction

    function void check_result(cfd_out_t got);
      cfd_out_t exp_r;
      results++;
      if (pending_q.size() == 0) begin
        $error("unexpected result: status %0d position %h", got.status, got.position);
        errors++;
        return;
      end
      exp_r = pending_q.pop_front();
      if (got.status !== exp_r.status) begin
        $error("status: expected %0d, actual %0d", exp_r.status, got.status);
        errors++;
      end
      if (got.position !== exp_r.position) begin
        $error("position: expected %h, actual %h", exp_r.position, got.position);
        errors++;
      end
    endfunction
  endclass

  logic                  clk_i = 0;
  logic                  rst_ni = 0;
  logic                  in_valid = 0;
  logic                  in_ready;
  cfd_in_t               in_data = '0;
  logic                  out_valid;
  logic                  out_ready = 0;
  cfd_out_t              out_data;
  logic                  cfg_we = 0;
  logic [CFG_IDX_W-1:0]  cfg_idx = REG_DELAY;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  cfd_scoreboard sb = new();
  int snd_idle = 0;
  int rcv_idle = 0;
  bit hold = 0;
  int items = 0;

  always begin
    #5 clk_i = 1;
    #5 clk_i = 0;
  end

  constant_fraction_discriminator dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid), .in_ready_o(in_ready), .in_data_i(in_data),
    .out_valid_o(out_valid), .out_ready_i(out_ready), .out_data_o(out_data),
    .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx), .cfg_data_i(cfg_data)
  );

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid && in_ready) sb.note_sample(in_data);
      if (out_valid && out_ready) sb.check_result(out_data);
    end
  end

  always @(posedge clk_i) begin
    out_ready <= !hold && ($urandom_range(99) >= rcv_idle);
  end

  initial begin
    #300_000_000;
    $display("** constant_fraction_discriminator: FAILED **");
    $finish;
  end

  task automatic send(input int s, input bit lst);
    if ($urandom_range(99) < snd_idle) begin
      in_valid <= 0;
      do @(posedge clk_i); while ($urandom_range(99) < snd_idle);
    end
    in_valid <= 1;
    in_data.sample <= 16'(s);
    in_data.last <= lst;
    @(posedge clk_i);
    while (!in_ready) @(posedge clk_i);
    items++;
  endtask

  task automatic write_regs(input int v[6]);
    for (int k = 0; k < 6; k++) begin
      cfg_we <= 1;
      cfg_idx <= CFG_IDX_W'(k);
      cfg_data <= CFG_DATA_W'(v[k]);
      sb.write_reg(CFG_IDX_W'(k), CFG_DATA_W'(v[k]));
      @(posedge clk_i);
    end
    cfg_we <= 0;
  endtask

  task automatic drain();
    in_valid <= 0;
    while (sb.pending_q.size() != 0) @(posedge clk_i);
    repeat (6000) @(posedge clk_i);
  endtask

  function automatic int clip16(int v);
    return v > 32767 ? 32767 : (v < -32768 ? -32768 : v);
  endfunction

  task automatic send_waveform();
    int kind, len, base, amp, t0, rise, fall, nz, s, x;
    kind = $urandom_range(99);
    if (kind < 10) begin
      len = $urandom_range(1, 4);
      for (int k = 0; k < len; k++) send($signed(16'($urandom)), k == len - 1);
    end else if (kind < 20) begin
      len = $urandom_range(5, 30);
      for (int k = 0; k < len; k++) send($signed(16'($urandom)), k == len - 1);
    end else begin
      len = $urandom_range(8, 40);
      base = sb.offs + $urandom_range(0, 40) - 20;
      amp = $urandom_range(100, 30000);
      if ($urandom_range(1)) amp = -amp;
      t0 = $urandom_range(0, len / 2);
      rise = $urandom_range(1, 6);
      fall = $urandom_range(2, 20);
      nz = $urandom_range(0, 8);
      for (int k = 0; k < len; k++) begin
        x = k - t0;
        if (x < 0) s = 0;
        else if (x < rise) s = amp * x / rise;
        else if (x < rise + fall) s = amp * (rise + fall - x) / fall;
        else s = 0;
        send(clip16(base + s + $urandom_range(0, 2 * nz) - nz), k == len - 1);
      end
    end
  endtask

  initial begin
    int settings[6][6];
    int v[6];
    bit stalled, paused;
    stalled = 0;
    paused = 0;
    settings = '{'{3, 32768, 0, 0, 50, 20},
                 '{0, 65535, -32768, -131072, 0, 0},
                 '{127, 0, 32767, 131071, 131071, 63},
                 '{64, 20000, 100, -500, 10, 1},
                 '{1, 45000, -200, 300, 200, 63},
                 '{2, 32768, 0, 0, 0, 20}};
    repeat (2) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    // Reset settings: short waveforms, field extremes and a clean step of each polarity.
    send(0, 1);
    send(32767, 0); send(-32768, 1);
    foreach (v[k]) v[k] = 0;
    for (int k = 0; k < 8; k++) send(k < 3 ? 0 : 2000, k == 7);
    for (int k = 0; k < 8; k++) send(k < 3 ? 0 : -2000, k == 7);
    drain();

    for (int p = 0; p < 6; p++) begin
      for (int k = 0; k < 6; k++) v[k] = settings[p][k];
      if (p == 5) begin
        v[0] = $urandom_range(0, 127); v[1] = $urandom_range(0, 65535);
        v[2] = $urandom_range(0, 65535); v[3] = $urandom_range(0, 262143);
        v[4] = $urandom_range(0, 300); v[5] = $urandom_range(0, 63);
      end
      write_regs(v);
      snd_idle = (p < 2) ? 10 : (p < 4) ? 67 : 0;
      rcv_idle = (p < 2) ? 67 : (p < 4) ? 10 : 0;
      while (items < 10 + 220 * (p + 1)) begin
        send_waveform();
        if (p == 0 && !stalled && items > 100) begin
          stalled = 1;
          fork
            begin
              hold <= 1;
              repeat (2000) @(posedge clk_i);
              hold <= 0;
            end
          join_none
          for (int k = 0; k < 30; k++) send(k, 1);
        end
        if (p == 3 && !paused && items > 800) begin
          paused = 1;
          in_valid <= 0;
          while (sb.pending_q.size() != 0) @(posedge clk_i);
        end
      end
      drain();
    end

    $display("Run covered %0d samples and %0d waveform results (%0d crossings found)",
             sb.samples, sb.results, sb.crossings);
    $display("across six register settings including the extremes of every field.");
    if (sb.errors == 0 && sb.pending_q.size() == 0) begin
      $display("** constant_fraction_discriminator: PASSED **");
    end else begin
      $display("** constant_fraction_discriminator: FAILED **");
    end
    $finish;
  end
endmodule
